/* rtl/touch_grid_key_qualifier_top_macros.svh */
// Assertion helpers shared by the key qualifier modules.
`ifndef TOUCH_GRID_KEY_QUALIFIER_TOP_MACROS_SVH
`define TOUCH_GRID_KEY_QUALIFIER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGKQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGKQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tgkq_pkg.sv */
package tgkq_pkg;

    // Field widths.
    localparam int SAMPLE_W = 12;
    localparam int KEY_W    = 4;
    localparam int HOLD_W   = 8;
    localparam int BAND_W   = 2;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [HOLD_W-1:0]   t_hold;
    typedef logic [BAND_W-1:0]   t_band;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    // Edge thresholds for both axes.
    typedef struct packed {
        t_sample x_low;
        t_sample x_mid;
        t_sample x_high;
        t_sample y_low;
        t_sample y_mid;
        t_sample y_high;
    } t_edges;

    // Register indexes.
    localparam t_reg_idx REG_X_LOW  = 3'd0;
    localparam t_reg_idx REG_X_MID  = 3'd1;
    localparam t_reg_idx REG_X_HIGH = 3'd2;
    localparam t_reg_idx REG_Y_LOW  = 3'd3;
    localparam t_reg_idx REG_Y_MID  = 3'd4;
    localparam t_reg_idx REG_Y_HIGH = 3'd5;
    localparam t_reg_idx REG_FAST   = 3'd6;

    // Reset values of the registers.
    localparam t_sample RST_X_LOW  = 12'd220;
    localparam t_sample RST_X_MID  = 12'd1040;
    localparam t_sample RST_X_HIGH = 12'd2020;
    localparam t_sample RST_Y_LOW  = 12'd220;
    localparam t_sample RST_Y_MID  = 12'd1020;
    localparam t_sample RST_Y_HIGH = 12'd2020;

    // Hold limits before auto-repeat and the counter ceiling.
    localparam t_hold HOLD_FAST = 8'd15;
    localparam t_hold HOLD_SLOW = 8'd25;
    localparam t_hold HOLD_MAX  = 8'd255;

    localparam t_key  NO_KEY    = 4'd0;
    localparam t_band BAND_NONE = 2'd0;
    localparam t_band BAND_ONE  = 2'd1;
    localparam t_band BAND_TWO  = 2'd2;
    localparam t_band BAND_THREE = 2'd3;
    localparam t_key  ROWS_PER_COL = 4'd3;

    // Default depth of the queue between classifier and qualifier.
    localparam int QUEUE_DEPTH_DEF = 4;

endpackage

/* rtl/tgkq_in_if.sv */
interface tgkq_in_if;
    import tgkq_pkg::*;

    logic    valid;
    logic    ready;
    t_sample x_sample;
    t_sample y_sample;

    modport source (output valid, output x_sample, output y_sample, input ready);
    modport sink (input valid, input x_sample, input y_sample, output ready);
endinterface

/* rtl/tgkq_out_if.sv */
interface tgkq_out_if;
    import tgkq_pkg::*;

    logic valid;
    logic ready;
    t_key key_code;

    modport source (output valid, output key_code, input ready);
    modport sink (input valid, input key_code, output ready);
endinterface

/* rtl/tgkq_front.sv */
module tgkq_front (
    tgkq_in_if.sink          i_in,
    input  tgkq_pkg::t_edges i_edges,
    input  logic             i_full,
    output logic             o_push,
    output tgkq_pkg::t_key   o_push_key
);
    import tgkq_pkg::*;

    // Place one axis reading into band 1..3, or none below the low edge.
    function automatic t_band axis_band(t_sample v, t_sample lo, t_sample mid, t_sample hi);
        t_band b;
        if (v >= lo && v < mid) begin
            b = BAND_ONE;
        end else if (v >= mid && v < hi) begin
            b = BAND_TWO;
        end else if (v >= hi) begin
            b = BAND_THREE;
        end else begin
            b = BAND_NONE;
        end
        return b;
    endfunction

    t_band col;
    t_band row;
    t_key  key;

    // Classify the sample pair into a grid cell.
    always_comb begin
        col = axis_band(i_in.x_sample, i_edges.x_low, i_edges.x_mid, i_edges.x_high);
        row = axis_band(i_in.y_sample, i_edges.y_low, i_edges.y_mid, i_edges.y_high);
        if (col != BAND_NONE && row != BAND_NONE) begin
            key = t_key'((t_key'(col) - t_key'(1)) * ROWS_PER_COL) + t_key'(row);
        end else begin
            key = NO_KEY;
        end
    end

    // A word is taken whenever the queue has room.
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign o_push_key = key;

endmodule

/* rtl/tgkq_queue.sv */
`include "touch_grid_key_qualifier_top_macros.svh"

module tgkq_queue #(
    parameter int DEPTH = tgkq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tgkq_pkg::t_key i_push_key,
    output logic           o_full,
    input  logic           i_pop,
    output tgkq_pkg::t_key o_pop_key,
    output logic           o_empty
);
    import tgkq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_key             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign o_pop_key = r_slot[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Pointers wrap at the last slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_key;
        end
    end

    `TGKQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL, "queue overfilled")
    `TGKQ_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")
    `TGKQ_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CNT_W'(1), "push not counted")

endmodule

/* rtl/tgkq_back.sv */
`include "touch_grid_key_qualifier_top_macros.svh"

module tgkq_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fast_mode,
    input  logic            i_empty,
    input  tgkq_pkg::t_key  i_key,
    output logic            o_pop,
    tgkq_out_if.source      o_out
);
    import tgkq_pkg::*;

    t_key  r_prev_key;
    t_hold r_hold_count;
    logic  r_out_valid;
    t_key  r_out_key;

    t_key  n_prev_key;
    t_hold n_hold_count;
    t_key  n_result;
    t_hold limit;
    logic  pop;

    assign limit = i_fast_mode ? HOLD_FAST : HOLD_SLOW;

    // Qualify the key against the last one and the hold counter.
    always_comb begin
        n_prev_key   = r_prev_key;
        n_hold_count = r_hold_count;
        n_result     = NO_KEY;
        if (i_key == NO_KEY) begin
            n_hold_count = '0;
        end else if (i_key != r_prev_key) begin
            n_prev_key   = i_key;
            n_hold_count = '0;
        end else begin
            if (r_hold_count != HOLD_MAX) begin
                n_hold_count = r_hold_count + t_hold'(1);
            end
            if (n_hold_count == t_hold'(1) || n_hold_count > limit) begin
                n_result = i_key;
            end
        end
    end

    // A word leaves the queue when the output register is free or being emptied.
    assign pop   = !i_empty && (!r_out_valid || o_out.ready);
    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_key   <= NO_KEY;
            r_hold_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop) begin
                r_prev_key   <= n_prev_key;
                r_hold_count <= n_hold_count;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_key <= n_result;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.key_code = r_out_key;

    `TGKQ_ASSERT_NOW(a_out_is_prev, i_clk, i_rst_n,
        r_out_valid && r_out_key != NO_KEY, r_out_key == r_prev_key,
        "reported key differs from held key")
    `TGKQ_ASSERT_NOW(a_hold_needs_key, i_clk, i_rst_n,
        r_hold_count != '0, r_prev_key != NO_KEY, "hold count without key")
    `TGKQ_ASSERT_NEXT(a_release_clears, i_clk, i_rst_n,
        pop && i_key == NO_KEY, r_hold_count == '0 && r_out_key == NO_KEY,
        "release did not clear hold")

endmodule

/* rtl/touch_grid_key_qualifier_top.sv */
// Touch grid key qualifier: one sample pair in, one key code out per pair.
// Each pair is queued, then moved into the output register when that register is free.
// Throughput: one pair per cycle while not full; queue and output reg decouple the sides.
// Reset (synchronous, active low) restores the edge and mode registers to their defaults,
// clears the held key, the hold counter, the queue and the output valid.
module touch_grid_key_qualifier_top #(
    parameter int QUEUE_DEPTH = tgkq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tgkq_in_if.sink                       i_in,
    tgkq_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgkq_pkg::PADDR_W-1:0]  paddr,
    input  logic [tgkq_pkg::PDATA_W-1:0]  pwdata,
    output logic [tgkq_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tgkq_pkg::*;

    t_edges   r_edges;
    logic     r_fast_mode;
    logic     wr_en;
    t_reg_idx reg_idx;
    t_sample  wr_val;

    logic     push;
    t_key     push_key;
    logic     full;
    logic     pop;
    t_key     pop_key;
    logic     empty;

    // Register port decode.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_val  = pwdata[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges.x_low  <= RST_X_LOW;
            r_edges.x_mid  <= RST_X_MID;
            r_edges.x_high <= RST_X_HIGH;
            r_edges.y_low  <= RST_Y_LOW;
            r_edges.y_mid  <= RST_Y_MID;
            r_edges.y_high <= RST_Y_HIGH;
            r_fast_mode    <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_X_LOW: begin
                    r_edges.x_low <= wr_val;
                end
                REG_X_MID: begin
                    r_edges.x_mid <= wr_val;
                end
                REG_X_HIGH: begin
                    r_edges.x_high <= wr_val;
                end
                REG_Y_LOW: begin
                    r_edges.y_low <= wr_val;
                end
                REG_Y_MID: begin
                    r_edges.y_mid <= wr_val;
                end
                REG_Y_HIGH: begin
                    r_edges.y_high <= wr_val;
                end
                REG_FAST: begin
                    r_fast_mode <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (reg_idx)
            REG_X_LOW:  prdata = PDATA_W'(r_edges.x_low);
            REG_X_MID:  prdata = PDATA_W'(r_edges.x_mid);
            REG_X_HIGH: prdata = PDATA_W'(r_edges.x_high);
            REG_Y_LOW:  prdata = PDATA_W'(r_edges.y_low);
            REG_Y_MID:  prdata = PDATA_W'(r_edges.y_mid);
            REG_Y_HIGH: prdata = PDATA_W'(r_edges.y_high);
            REG_FAST:   prdata = PDATA_W'(r_fast_mode);
            default:    prdata = '0;
        endcase
    end

    // Classifier front end.
    tgkq_front u_front (
        .i_in       (i_in),
        .i_edges    (r_edges),
        .i_full     (full),
        .o_push     (push),
        .o_push_key (push_key)
    );

    // Queue between classifier and qualifier.
    tgkq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_key (push_key),
        .o_full     (full),
        .i_pop      (pop),
        .o_pop_key  (pop_key),
        .o_empty    (empty)
    );

    // Hold and repeat qualifier back end.
    tgkq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fast_mode (r_fast_mode),
        .i_empty     (empty),
        .i_key       (pop_key),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import tgkq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE_GAP   = 4;
    localparam int HOLD_OFF_LEN = 200;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
    // Address 7 decodes to no register; writes there must change nothing.
    localparam t_reg_idx REG_SPARE = 3'd7;

    typedef enum {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} t_rx_mode;
    typedef enum {EDGES_SORTED, EDGES_SHUFFLED, EDGES_DEFAULT, EDGES_EXTREME} t_edge_style;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tgkq_in_if  pair_ch ();
    tgkq_out_if key_ch ();

    touch_grid_key_qualifier_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (pair_ch),
        .o_out   (key_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the block's registers and key history.
    t_edges edge_q;
    logic   fast_q;
    t_key   held_key;
    t_hold  held_cnt;

    t_key expected_keys[$];
    int   mismatch_count = 0;
    int   items_sent     = 0;
    int   burst_left     = 0;
    int   hold_off_len   = 0;
    int   cycle_count    = 0;
    bit   steady_send    = 1'b0;

    // Free-running clock, 2 ns period.
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Places one axis reading into band 1..3, or none.
    function automatic t_band band_of(t_sample v, t_sample lo, t_sample mid, t_sample hi);
        if (v >= lo && v < mid) begin
            return BAND_ONE;
        end else if (v >= mid && v < hi) begin
            return BAND_TWO;
        end else if (v >= hi) begin
            return BAND_THREE;
        end
        return BAND_NONE;
    endfunction

    // Column-major cell code for a sample pair under the current edges.
    function automatic t_key cell_key(t_sample xs, t_sample ys);
        t_band col;
        t_band row;
        col = band_of(xs, edge_q.x_low, edge_q.x_mid, edge_q.x_high);
        row = band_of(ys, edge_q.y_low, edge_q.y_mid, edge_q.y_high);
        if (col == BAND_NONE || row == BAND_NONE) begin
            return NO_KEY;
        end
        return t_key'((int'(col) - 1) * int'(ROWS_PER_COL) + int'(row));
    endfunction

    // Advances the key history by one pair and returns the key to report.
    function automatic t_key qualify_pair(t_sample xs, t_sample ys);
        t_key  key;
        t_key  reported;
        t_hold limit;
        key      = cell_key(xs, ys);
        reported = NO_KEY;
        limit    = fast_q ? HOLD_FAST : HOLD_SLOW;
        if (key == NO_KEY) begin
            held_cnt = '0;
        end else if (key != held_key) begin
            held_key = key;
            held_cnt = '0;
        end else begin
            if (held_cnt != HOLD_MAX) begin
                held_cnt = held_cnt + 1'b1;
            end
            if (held_cnt == 1 || held_cnt > limit) begin
                reported = key;
            end
        end
        return reported;
    endfunction

    // Random axis value: extremes, values next to an edge, or anywhere.
    function automatic t_sample rand_axis(t_sample lo, t_sample mid, t_sample hi);
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            1, 2: begin
                case ($urandom_range(0, 2))
                    0: v = int'(lo);
                    1: v = int'(mid);
                    default: v = int'(hi);
                endcase
                v = v + int'($urandom_range(0, 6)) - 3;
                if (v < 0) v = 0;
                if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            end
            default: v = $urandom_range(0, SAMPLE_MAX);
        endcase
        return t_sample'(v);
    endfunction

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Sends one sample pair, in bursts with random gaps, and records the expected key.
    task automatic send_pair(t_sample xs, t_sample ys);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0 && !steady_send) begin
                pair_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pair_ch.valid    <= 1'b1;
        pair_ch.x_sample <= xs;
        pair_ch.y_sample <= ys;
        @(posedge clk);
        while (!pair_ch.ready) @(posedge clk);
        expected_keys.push_back(qualify_pair(xs, ys));
        items_sent++;
    endtask

    // Holds one cell for a number of samples, with small jitter that stays in the cell.
    task automatic send_key_run(int len);
        t_sample bx;
        t_sample by;
        t_sample xs;
        t_sample ys;
        t_key    key;
        bx  = rand_axis(edge_q.x_low, edge_q.x_mid, edge_q.x_high);
        by  = rand_axis(edge_q.y_low, edge_q.y_mid, edge_q.y_high);
        key = cell_key(bx, by);
        repeat (len) begin
            xs = bx;
            ys = by;
            if ($urandom_range(0, 1)) begin
                xs = bx ^ t_sample'($urandom_range(0, 15));
                ys = by ^ t_sample'($urandom_range(0, 15));
                if (cell_key(xs, ys) != key) begin
                    xs = bx;
                    ys = by;
                end
            end
            send_pair(xs, ys);
        end
    endtask

    // Mostly held keys of assorted lengths, with some lone noise pairs.
    task automatic send_mix(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: send_pair(t_sample'($urandom_range(0, SAMPLE_MAX)),
                             t_sample'($urandom_range(0, SAMPLE_MAX)));
                1: send_key_run($urandom_range(1, 3));
                2: send_key_run($urandom_range(30, 60));
                default: send_key_run($urandom_range(1, 35));
            endcase
        end
    endtask

    // Stops sending and waits until every expected key has come back.
    task automatic settle();
        pair_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_keys.size() != 0) @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // Register write with random upper bits, which the block must mask off.
    task automatic write_reg(t_reg_idx idx, int unsigned val);
        logic [PDATA_W-1:0] word;
        word = $urandom_range(0, 1) ? PDATA_W'($urandom()) : '0;
        if (idx == REG_FAST) begin
            word[0] = val[0];
        end else begin
            word[SAMPLE_W-1:0] = val[SAMPLE_W-1:0];
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // The bus goes idle before the next transfer may start.
        @(posedge clk);
        case (idx)
            REG_X_LOW:  edge_q.x_low  = word[SAMPLE_W-1:0];
            REG_X_MID:  edge_q.x_mid  = word[SAMPLE_W-1:0];
            REG_X_HIGH: edge_q.x_high = word[SAMPLE_W-1:0];
            REG_Y_LOW:  edge_q.y_low  = word[SAMPLE_W-1:0];
            REG_Y_MID:  edge_q.y_mid  = word[SAMPLE_W-1:0];
            REG_Y_HIGH: edge_q.y_high = word[SAMPLE_W-1:0];
            REG_FAST:   fast_q        = word[0];
            default: ;
        endcase
    endtask

    task automatic program_edges(t_sample e[6], logic fast);
        settle();
        write_reg(REG_X_LOW, e[0]);
        write_reg(REG_X_MID, e[1]);
        write_reg(REG_X_HIGH, e[2]);
        write_reg(REG_Y_LOW, e[3]);
        write_reg(REG_Y_MID, e[4]);
        write_reg(REG_Y_HIGH, e[5]);
        write_reg(REG_FAST, fast);
    endtask

    // Every cell entered on its lowest and left on its highest value, plus no-touch pairs.
    task automatic test_reset_defaults();
        t_sample col_lo[3];
        t_sample col_hi[3];
        t_sample row_lo[3];
        t_sample row_hi[3];
        col_lo = '{RST_X_LOW, RST_X_MID, RST_X_HIGH};
        col_hi = '{RST_X_MID - 1'b1, RST_X_HIGH - 1'b1, t_sample'(SAMPLE_MAX)};
        row_lo = '{RST_Y_LOW, RST_Y_MID, RST_Y_HIGH};
        row_hi = '{RST_Y_MID - 1'b1, RST_Y_HIGH - 1'b1, t_sample'(SAMPLE_MAX)};
        send_pair('0, '0);
        send_pair(RST_X_LOW - 1'b1, RST_Y_LOW - 1'b1);
        send_pair(t_sample'(SAMPLE_MAX), '0);
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                send_pair(col_lo[c], row_lo[r]);
                send_pair(col_hi[c], row_hi[r]);
            end
        end
        settle();
    endtask

    // Report on the second sample, silence, then repeat past the limit in both modes.
    task automatic test_hold_and_repeat();
        write_reg(REG_FAST, 1);
        repeat (30) send_pair(12'd1500, 12'd1500);
        // A release keeps the last key, so the same key reports on its first return.
        send_pair('0, '0);
        repeat (3) send_pair(12'd1500, 12'd1500);
        settle();
        write_reg(REG_FAST, 0);
        repeat (40) send_pair(12'd3000, 12'd500);
        settle();
    endtask

    // A key held far past 255 samples must keep repeating.
    task automatic test_counter_saturation();
        repeat (300) send_pair(12'd500, 12'd3000);
        send_pair(12'd3000, 12'd3000);
        repeat (3) send_pair(12'd500, 12'd3000);
        settle();
    endtask

    // Extreme, reversed and equal edges, and a write to the unused address.
    task automatic test_edge_settings();
        t_sample e[6];
        e = '{'0, '0, '0, '0, '0, '0};
        program_edges(e, 1'b1);
        send_mix(40);
        e = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
        program_edges(e, 1'b0);
        send_pair(12'hFFF, 12'hFFF);
        send_pair(12'hFFF, 12'hFFF);
        send_pair(12'hFFE, 12'hFFF);
        send_mix(40);
        e = '{12'd3000, 12'd2000, 12'd1000, 12'd3500, 12'd1500, 12'd500};
        program_edges(e, 1'b1);
        send_mix(60);
        e = '{12'd2048, 12'd2048, 12'd2048, 12'd100, 12'd100, 12'd4000};
        program_edges(e, 1'b0);
        send_mix(40);
        settle();
        write_reg(REG_SPARE, $urandom());
        send_mix(40);
        e = '{RST_X_LOW, RST_X_MID, RST_X_HIGH, RST_Y_LOW, RST_Y_MID, RST_Y_HIGH};
        program_edges(e, 1'b0);
        settle();
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        steady_send  = 1'b1;
        hold_off_len = HOLD_OFF_LEN;
        send_key_run(80);
        steady_send  = 1'b0;
        send_mix(40);
        settle();
    endtask

    // Long random part across many register settings.
    task automatic test_random_sequences();
        t_sample     e[6];
        t_sample     t;
        t_edge_style style;
        int          stop_at;
        stop_at = items_sent + 1300;
        while (items_sent < stop_at) begin
            style = t_edge_style'($urandom_range(0, 3));
            foreach (e[i]) e[i] = t_sample'($urandom_range(0, SAMPLE_MAX));
            case (style)
                EDGES_SORTED: begin
                    for (int a = 0; a < 6; a += 3) begin
                        repeat (2) begin
                            for (int i = a; i < a + 2; i++) begin
                                if (e[i] > e[i+1]) begin
                                    t = e[i];
                                    e[i] = e[i+1];
                                    e[i+1] = t;
                                end
                            end
                        end
                    end
                end
                EDGES_DEFAULT: begin
                    e = '{RST_X_LOW, RST_X_MID, RST_X_HIGH, RST_Y_LOW, RST_Y_MID, RST_Y_HIGH};
                end
                EDGES_EXTREME: begin
                    foreach (e[i]) e[i] = $urandom_range(0, 1) ? t_sample'(SAMPLE_MAX) : '0;
                end
                default: ;
            endcase
            program_edges(e, logic'($urandom_range(0, 1)));
            send_mix(250);
        end
        settle();
    endtask

    // Receiver: changes its stall pattern every so often, and honors a requested hold-off.
    initial begin : receiver
        t_rx_mode mode;
        int       span;
        int       phase;
        key_ch.ready = 1'b0;
        mode  = RX_OPEN;
        span  = 0;
        phase = 0;
        forever begin
            @(posedge clk);
            if (hold_off_len != 0) begin
                key_ch.ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            if (span == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                span = $urandom_range(20, 150);
            end
            span--;
            phase++;
            case (mode)
                RX_OPEN:         key_ch.ready <= 1'b1;
                RX_COIN:         key_ch.ready <= 1'($urandom_range(0, 1));
                RX_EVERY_FOURTH: key_ch.ready <= (phase % 4 == 0);
                default:         key_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Compares each accepted key word with the oldest expectation.
    always @(posedge clk) begin
        t_key want;
        if (rst_n && key_ch.valid && key_ch.ready) begin
            if (expected_keys.size() == 0) begin
                note_mismatch($sformatf("unexpected key word %0d", key_ch.key_code));
            end else begin
                want = expected_keys.pop_front();
                if (key_ch.key_code !== want) begin
                    note_mismatch($sformatf("key_code expected %0d, got %0d",
                                            want, key_ch.key_code));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        pair_ch.valid    = 1'b0;
        pair_ch.x_sample = '0;
        pair_ch.y_sample = '0;
        edge_q   = '{RST_X_LOW, RST_X_MID, RST_X_HIGH, RST_Y_LOW, RST_Y_MID, RST_Y_HIGH};
        fast_q   = 1'b0;
        held_key = NO_KEY;
        held_cnt = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_hold_and_repeat();
        test_counter_saturation();
        test_edge_settings();
        test_backpressure();
        test_random_sequences();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
